@@ rtl/core/dgs_pkg.sv @@
// ----------------------------------------------------------------------------
// dgs_pkg: shared types and constants for the stage scheduler
// Request and result layouts, opcodes and stage status codes.
// ----------------------------------------------------------------------------
package dgs_pkg;

  localparam int MAX_STAGES_DEF = 32;
  localparam int FUNC_W         = 2;
  localparam int DEPS_W         = 32;
  localparam int STAGE_W        = 5;
  localparam int CNT_W          = 6;
  localparam int CHUNK_W        = 8;
  localparam int NCHUNK         = DEPS_W / CHUNK_W;
  localparam int PART_W         = $clog2(CHUNK_W + 1);
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_NEXT  = 2'd1,
    FUNC_DONE  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_RUN  = 2'd1,
    ST_OK   = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  // decoded request as queued between front and back
  typedef struct packed {
    func_t               op;
    logic [DEPS_W-1:0]   deps;
    logic [STAGE_W-1:0]  index;
    logic                success;
    logic [DEPS_W-1:0]   idx_mask;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [STAGE_W-1:0] stage;
    logic               all_done;
    logic [CNT_W-1:0]   failure_count;
    logic [CNT_W-1:0]   stage_count;
  } res_t;

endpackage

@@ rtl/core/dependency_gated_stage_scheduler.sv @@
// ----------------------------------------------------------------------------
// dependency_gated_stage_scheduler: stage table with dependency-gated dispatch
// A request passes the front register and the queue, then the sequencer.
// Requests run one at a time: the execution sequencer (pop, execute, pick
//   for dispatch-next, status sum, result load) takes the next only after a result load.
// Reset (rst_n low, synchronous) empties the table and drops queued requests;
//   table entries themselves are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module dependency_gated_stage_scheduler import dgs_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [DEPS_W-1:0]  in_deps,
  input  logic [STAGE_W-1:0] in_index,
  input  logic               in_success,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [STAGE_W-1:0] out_stage,
  output logic               out_all_done,
  output logic [CNT_W-1:0]   out_failure_count,
  output logic [CNT_W-1:0]   out_stage_count
);

  // front -> queue
  logic push_valid;
  logic push_ready;
  req_t push_req;

  // queue -> back
  logic pop_valid;
  logic pop_ready;
  req_t pop_req;

  res_t res;

  // Front end: registers one request and decodes it (opcode, one-hot of
  // the completion index used for failure spread).
  dgs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_deps    (in_deps),
    .in_index   (in_index),
    .in_success (in_success),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  // Short queue so intake keeps going while the back end works or its
  // result register waits on the consumer.
  dgs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_req   (push_req),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_req   (pop_req)
  );

  // Back end: the stage table, readiness check, lowest-ready pick and a
  // two-level count tree for failures and outstanding work.
  dgs_back #(
    .MAX_STAGES (MAX_STAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_req     (pop_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_ok            = res.ok;
  assign out_stage         = res.stage;
  assign out_all_done      = res.all_done;
  assign out_failure_count = res.failure_count;
  assign out_stage_count   = res.stage_count;

  // refused request never names a stage
  a_refused_stage_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_stage == '0)
    else $error("refused request reports a non-zero stage");

  // failures come from table entries only
  a_fail_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_failure_count <= out_stage_count) &&
                  (out_stage_count <= CNT_W'(MAX_STAGES)))
    else $error("failure or stage count out of range");

  // empty table is finished and clean
  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stage_count == '0 |-> out_all_done && out_failure_count == '0)
    else $error("empty table reports outstanding work or failures");

  // an added or dispatched stage lies inside the table
  a_stage_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok && out_stage != '0 |-> CNT_W'(out_stage) < out_stage_count)
    else $error("reported stage lies beyond the table");

endmodule

@@ rtl/core/dgs_front.sv @@
// ----------------------------------------------------------------------------
// dgs_front: request intake
// Takes requests, decodes the opcode and index mask, hands them to the queue.
// ----------------------------------------------------------------------------
module dgs_front import dgs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [DEPS_W-1:0]  in_deps,
  input  logic [STAGE_W-1:0] in_index,
  input  logic               in_success,
  output logic               push_valid,
  input  logic               push_ready,
  output req_t               push_req
);

  logic hold_r;
  req_t req_r;
  req_t req_nxt;

  always_comb begin
    req_nxt.op       = func_t'(in_func);
    req_nxt.deps     = in_deps;
    req_nxt.index    = in_index;
    req_nxt.success  = in_success;
    req_nxt.idx_mask = DEPS_W'(1) << in_index;
  end

  assign in_ready   = !hold_r || push_ready;
  assign push_valid = hold_r;
  assign push_req   = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_r <= 1'b1;
    end else if (push_ready) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_nxt;
    end
  end

endmodule

@@ rtl/core/dgs_queue.sv @@
// ----------------------------------------------------------------------------
// dgs_queue: short request queue
// Two-entry FIFO decoupling intake from execution.
// ----------------------------------------------------------------------------
module dgs_queue import dgs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  req_t wr_req,
  output logic rd_valid,
  input  logic rd_ready,
  output req_t rd_req
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  req_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = cnt_r != (PTR_W+1)'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_req   = q_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) q_r[wr_ptr_r] <= wr_req;
  end

endmodule

@@ rtl/core/dgs_back.sv @@
// ----------------------------------------------------------------------------
// dgs_back: stage table and execution sequencer
// Holds the stage table, runs each request, sums status and drives results.
// ----------------------------------------------------------------------------
module dgs_back import dgs_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  req_t q_req,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PICK, S_SUM, S_EMIT} state_t;

  state_t             state_r;
  req_t               req_r;
  status_t            status_r [MAX_STAGES];
  logic [DEPS_W-1:0]  deps_r [MAX_STAGES];
  logic [CNT_W-1:0]   count_r;
  logic [DEPS_W-1:0]  ready_r;
  logic               ok_r;
  logic [STAGE_W-1:0] stage_r;
  logic [PART_W-1:0]  fail_part_r [NCHUNK];
  logic [NCHUNK-1:0]  busy_part_r;
  res_t               res_r;
  logic               out_valid_r;

  logic [DEPS_W-1:0]  live;
  logic [DEPS_W-1:0]  succ_mask;
  logic [DEPS_W-1:0]  fail_vec;
  logic [DEPS_W-1:0]  busy_vec;
  logic [DEPS_W-1:0]  ready_vec;
  logic [STAGE_W-1:0] pick_idx;
  logic [PART_W-1:0]  fail_part [NCHUNK];
  logic [NCHUNK-1:0]  busy_part;
  logic [CNT_W-1:0]   fail_total;

  // per-entry views; bits past the table stay clear so such deps never pass
  always_comb begin
    live      = '0;
    succ_mask = '0;
    fail_vec  = '0;
    busy_vec  = '0;
    ready_vec = '0;
    for (int i = 0; i < MAX_STAGES; i++) begin
      live[i]      = CNT_W'(i) < count_r;
      succ_mask[i] = live[i] && (status_r[i] == ST_OK);
      fail_vec[i]  = live[i] && (status_r[i] == ST_FAIL);
      busy_vec[i]  = live[i] && ((status_r[i] == ST_WAIT) || (status_r[i] == ST_RUN));
    end
    for (int i = 0; i < MAX_STAGES; i++) begin
      ready_vec[i] = live[i] && (status_r[i] == ST_WAIT) &&
                     ((deps_r[i] & ~succ_mask) == '0);
    end
  end

  // lowest ready entry
  always_comb begin
    pick_idx = '0;
    for (int i = MAX_STAGES - 1; i >= 0; i--) begin
      if (ready_r[i]) pick_idx = STAGE_W'(i);
    end
  end

  // first level of the status count tree
  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      fail_part[c] = '0;
      for (int k = 0; k < CHUNK_W; k++) begin
        fail_part[c] = fail_part[c] + PART_W'(fail_vec[c*CHUNK_W + k]);
      end
      busy_part[c] = |busy_vec[c*CHUNK_W +: CHUNK_W];
    end
  end

  always_comb begin
    fail_total = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      fail_total = fail_total + CNT_W'(fail_part_r[c]);
    end
  end

  assign q_ready   = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; a fresh one loaded in S_EMIT keeps valid high
      if (out_valid_r && out_ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r   <= q_req;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          ok_r    <= 1'b0;
          stage_r <= '0;
          state_r <= S_SUM;
          case (req_r.op)
            FUNC_ADD: begin
              if (count_r < CNT_W'(MAX_STAGES)) begin
                for (int i = 0; i < MAX_STAGES; i++) begin
                  if (count_r == CNT_W'(i)) begin
                    deps_r[i]   <= req_r.deps;
                    status_r[i] <= ST_WAIT;
                  end
                end
                count_r <= count_r + 1'b1;
                ok_r    <= 1'b1;
                stage_r <= count_r[STAGE_W-1:0];
              end
            end
            FUNC_NEXT: begin
              ready_r <= ready_vec;
              state_r <= S_PICK;
            end
            FUNC_DONE: begin
              if (CNT_W'(req_r.index) < count_r) begin
                for (int i = 0; i < MAX_STAGES; i++) begin
                  if (STAGE_W'(i) == req_r.index) begin
                    status_r[i] <= req_r.success ? ST_OK : ST_FAIL;
                  end else if (!req_r.success && live[i] && (status_r[i] == ST_WAIT) &&
                               ((deps_r[i] & req_r.idx_mask) != '0)) begin
                    // direct dependents only
                    status_r[i] <= ST_FAIL;
                  end
                end
                ok_r <= 1'b1;
              end
            end
            FUNC_CLEAR: begin
              count_r <= '0;
              ok_r    <= 1'b1;
            end
            default: begin
              ok_r <= 1'b0;
            end
          endcase
        end
        S_PICK: begin
          if (ready_r != '0) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
              if (STAGE_W'(i) == pick_idx) status_r[i] <= ST_RUN;
            end
            ok_r    <= 1'b1;
            stage_r <= pick_idx;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          for (int c = 0; c < NCHUNK; c++) begin
            fail_part_r[c] <= fail_part[c];
          end
          busy_part_r <= busy_part;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            res_r.ok            <= ok_r;
            res_r.stage         <= stage_r;
            res_r.all_done      <= ~|busy_part_r;
            res_r.failure_count <= fail_total;
            res_r.stage_count   <= count_r;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
